[hdl/spq_pkg.sv]
// shared types, constants and index helpers for the sorted priority queue
package spq_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DATA_W  = 32;
	localparam int PRIO_W  = 16;
	localparam int ENTRY_W = DATA_W + PRIO_W;

	// one stored entry: data word above priority
	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic signed [PRIO_W-1:0] prio;
	} entry_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_ENQ_STEP,
		S_ENQ_CMP,
		S_DEQ_DONE
	} ctrl_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    capture;
		logic    enq_open;
		logic    rd_head;
		logic    rd_prev;
		logic    wr_new;
		logic    wr_shift;
		logic    pop;
		logic    res_load;
		logic    take_front;
		status_t res_status;
	} ctl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic action_deq;
		logic empty;
		logic full;
		logic at_head;
		logic less;
	} dp_stat_t;

	// circular successor
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] r;
		if (p == IDX_W'(DEPTH - 1)) r = '0;
		else r = IDX_W'(p + 1'b1);
		return r;
	endfunction

	// circular predecessor
	function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] r;
		if (p == '0) r = IDX_W'(DEPTH - 1);
		else r = IDX_W'(p - 1'b1);
		return r;
	endfunction

endpackage

[hdl/sorted_priority_queue_top.sv]
// top level of the sorted priority queue
//
// A bounded queue of spq_pkg::DEPTH entries kept in priority order, oldest
// first among equal priorities. A command beat is taken at a rising edge
// where start is high and busy is low: action 0 enqueues item_data with
// item_priority, action 1 dequeues the front entry.
// Every command gives one result beat: done is high for exactly one cycle
// with status, front_data, front_priority, now_empty and now_full valid.
// The receiver cannot stall; the beat is shown once and is gone.
// Sequence from the accepting edge to the done cycle:
//   refused enqueue or dequeue: the result is loaded in the dispatch state
//   dequeue: registered read of the head entry, then the result is loaded
//   enqueue: one read and one write of the entry ram for each queued entry
//   of strictly lower priority that the new entry passes, then the new
//   entry is written at the head or behind the first entry that it does
//   not pass, and the result is loaded with that write
// busy is low in the done cycle, so the next command can follow at once.
// Reset empties the queue (pointers to zero); the entry ram is not cleared.
module sorted_priority_queue_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               action,
	input  logic signed [spq_pkg::DATA_W-1:0]  item_data,
	input  logic signed [spq_pkg::PRIO_W-1:0]  item_priority,
	output logic                               done,
	output logic [1:0]                         status,
	output logic signed [spq_pkg::DATA_W-1:0]  front_data,
	output logic signed [spq_pkg::PRIO_W-1:0]  front_priority,
	output logic                               now_empty,
	output logic                               now_full
);

	spq_pkg::ctl_cmd_t cmd;
	spq_pkg::dp_stat_t stat;

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	spq_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.action         (action),
		.item_data      (item_data),
		.item_priority  (item_priority),
		.done           (done),
		.status         (status),
		.front_data     (front_data),
		.front_priority (front_priority),
		.now_empty      (now_empty),
		.now_full       (now_full)
	);

endmodule

[hdl/spq_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
module spq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule

[hdl/spq_ctrl.sv]
// controller state machine: sequences enqueue insertion and dequeue
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  spq_pkg::dp_stat_t stat,
	output spq_pkg::ctl_cmd_t cmd,
	output logic              busy
);

	spq_pkg::ctrl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= spq_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.res_status = spq_pkg::STAT_DONE;
		busy           = 1'b1;
		case (state_q)
			spq_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = spq_pkg::S_DISPATCH;
				end
			end
			spq_pkg::S_DISPATCH: begin
				if (!stat.action_deq) begin
					if (stat.full) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = spq_pkg::STAT_FULL;
						state_d        = spq_pkg::S_IDLE;
					end else begin
						cmd.enq_open = 1'b1;
						state_d      = spq_pkg::S_ENQ_STEP;
					end
				end else if (stat.empty) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = spq_pkg::STAT_EMPTY;
					state_d        = spq_pkg::S_IDLE;
				end else begin
					cmd.rd_head = 1'b1;
					state_d     = spq_pkg::S_DEQ_DONE;
				end
			end
			// stop at head, else fetch the entry ahead
			spq_pkg::S_ENQ_STEP: begin
				if (stat.at_head) begin
					cmd.wr_new   = 1'b1;
					cmd.res_load = 1'b1;
					state_d      = spq_pkg::S_IDLE;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d     = spq_pkg::S_ENQ_CMP;
				end
			end
			// move the lower entry back or drop the new one in place
			spq_pkg::S_ENQ_CMP: begin
				if (stat.less) begin
					cmd.wr_shift = 1'b1;
					state_d      = spq_pkg::S_ENQ_STEP;
				end else begin
					cmd.wr_new   = 1'b1;
					cmd.res_load = 1'b1;
					state_d      = spq_pkg::S_IDLE;
				end
			end
			spq_pkg::S_DEQ_DONE: begin
				cmd.pop        = 1'b1;
				cmd.res_load   = 1'b1;
				cmd.take_front = 1'b1;
				state_d        = spq_pkg::S_IDLE;
			end
			default: begin
				state_d = spq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[hdl/spq_dp.sv]
// datapath: entry store, head and tail pointers, insertion cursor, result registers
module spq_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spq_pkg::ctl_cmd_t                  cmd,
	output spq_pkg::dp_stat_t                  stat,
	input  logic                               action,
	input  logic signed [spq_pkg::DATA_W-1:0]  item_data,
	input  logic signed [spq_pkg::PRIO_W-1:0]  item_priority,
	output logic                               done,
	output logic [1:0]                         status,
	output logic signed [spq_pkg::DATA_W-1:0]  front_data,
	output logic signed [spq_pkg::PRIO_W-1:0]  front_priority,
	output logic                               now_empty,
	output logic                               now_full
);

	logic [spq_pkg::IDX_W-1:0] head_q, tail_q, pos_q;
	logic                      empty_q, action_q, done_q;
	spq_pkg::entry_t           new_q, rd_entry, wr_entry;
	spq_pkg::status_t          status_q;
	logic signed [spq_pkg::DATA_W-1:0] fdata_q;
	logic signed [spq_pkg::PRIO_W-1:0] fprio_q;
	logic [spq_pkg::ENTRY_W-1:0] rdata;
	logic [spq_pkg::IDX_W-1:0]   raddr;
	logic                        full;

	assign full = !empty_q && (spq_pkg::next_idx(tail_q) == head_q);

	// entry store
	assign raddr    = cmd.rd_head ? head_q : spq_pkg::prev_idx(pos_q);
	assign wr_entry = cmd.wr_shift ? rd_entry : new_q;
	assign rd_entry = spq_pkg::entry_t'(rdata);

	spq_ram #(
		.WIDTH (spq_pkg::ENTRY_W),
		.DEPTH (spq_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.wr_new || cmd.wr_shift),
		.waddr (pos_q),
		.wdata (spq_pkg::ENTRY_W'(wr_entry)),
		.re    (cmd.rd_head || cmd.rd_prev),
		.raddr (raddr),
		.rdata (rdata)
	);

	// captured beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			new_q.data <= item_data;
			new_q.prio <= item_priority;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) action_q <= 1'b0;
		else if (cmd.capture) action_q <= action;
	end

	// queue pointers and insertion cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			pos_q   <= '0;
			empty_q <= 1'b1;
		end else begin
			if (cmd.enq_open) begin
				if (empty_q) begin
					head_q  <= '0;
					tail_q  <= '0;
					pos_q   <= '0;
					empty_q <= 1'b0;
				end else begin
					tail_q <= spq_pkg::next_idx(tail_q);
					pos_q  <= spq_pkg::next_idx(tail_q);
				end
			end
			if (cmd.wr_shift) pos_q <= spq_pkg::prev_idx(pos_q);
			if (cmd.pop) begin
				if (head_q == tail_q) begin
					head_q  <= '0;
					tail_q  <= '0;
					empty_q <= 1'b1;
				end else begin
					head_q <= spq_pkg::next_idx(head_q);
				end
			end
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= cmd.res_load;
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= cmd.res_status;
			fdata_q  <= cmd.take_front ? rd_entry.data : '0;
			fprio_q  <= cmd.take_front ? rd_entry.prio : '0;
		end
	end

	// status back to controller
	always_comb begin
		stat.action_deq = action_q;
		stat.empty      = empty_q;
		stat.full       = full;
		stat.at_head    = (pos_q == head_q);
		stat.less       = (rd_entry.prio < new_q.prio);
	end

	assign done           = done_q;
	assign status         = 2'(status_q);
	assign front_data     = fdata_q;
	assign front_priority = fprio_q;
	assign now_empty      = empty_q;
	assign now_full       = full;

endmodule

[hdl/spq_checker.sv]
// port-level checker for the sorted priority queue, bound to the top level
module spq_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input logic [1:0]                         status,
	input logic signed [spq_pkg::DATA_W-1:0]  front_data,
	input logic signed [spq_pkg::PRIO_W-1:0]  front_priority,
	input logic                               now_empty,
	input logic                               now_full
);

	// a taken command makes the block busy next cycle
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after command beat");

	// a result beat never comes without a command in flight before it
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result beat without command in flight");

	// refusals carry zero front fields
	a_zero_front: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != 2'(spq_pkg::STAT_DONE) |-> front_data == '0 && front_priority == '0)
		else $error("refused beat carries front data");

	// empty and full never together
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(now_empty && now_full))
		else $error("queue both empty and full");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.status         (status),
	.front_data     (front_data),
	.front_priority (front_priority),
	.now_empty      (now_empty),
	.now_full       (now_full)
);

[sim/sorted_priority_queue_top_tb.sv]
// self-checking testbench for the sorted priority queue top level
module sorted_priority_queue_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// command codes on the action input
	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	localparam int RANDOM_BEATS = 1480;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_CYCLES = 40;

	// one entry as held by the software copy of the queue
	typedef struct {
		logic signed [spq_pkg::DATA_W-1:0] data;
		logic signed [spq_pkg::PRIO_W-1:0] prio;
	} held_entry_t;

	// one result beat as it should appear on the outputs
	typedef struct {
		spq_pkg::status_t                  code;
		logic signed [spq_pkg::DATA_W-1:0] data;
		logic signed [spq_pkg::PRIO_W-1:0] prio;
		logic                              empty;
		logic                              full;
	} queue_result_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              start = 1'b0;
	logic                              busy;
	logic                              action = ACT_ENQ;
	logic signed [spq_pkg::DATA_W-1:0] item_data = '0;
	logic signed [spq_pkg::PRIO_W-1:0] item_priority = '0;
	logic                              done;
	logic [1:0]                        status;
	logic signed [spq_pkg::DATA_W-1:0] front_data;
	logic signed [spq_pkg::PRIO_W-1:0] front_priority;
	logic                              now_empty;
	logic                              now_full;

	// software copy of the queue, front entry at index 0
	held_entry_t   queued [spq_pkg::DEPTH];
	int            queued_count = 0;
	queue_result_t outcomes_due [$];

	int error_count = 0;
	int beats_sent  = 0;
	int cycle_count = 0;

	sorted_priority_queue_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.item_data      (item_data),
		.item_priority  (item_priority),
		.done           (done),
		.status         (status),
		.front_data     (front_data),
		.front_priority (front_priority),
		.now_empty      (now_empty),
		.now_full       (now_full)
	);

	always #5 clk = ~clk;

	// run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// apply one accepted command to the queue copy and queue up its result
	function automatic void model_queue_op(input logic act,
			input logic signed [spq_pkg::DATA_W-1:0] data,
			input logic signed [spq_pkg::PRIO_W-1:0] prio);
		queue_result_t r;
		int            pos;
		r.code = spq_pkg::STAT_DONE;
		r.data = '0;
		r.prio = '0;
		if (act == ACT_ENQ) begin
			if (queued_count == spq_pkg::DEPTH) begin
				r.code = spq_pkg::STAT_FULL;
			end else begin
				// new entry goes behind every entry of equal or higher priority
				pos = queued_count;
				while (pos > 0 && queued[pos-1].prio < prio) begin
					queued[pos] = queued[pos-1];
					pos--;
				end
				queued[pos].data = data;
				queued[pos].prio = prio;
				queued_count++;
			end
		end else begin
			if (queued_count == 0) begin
				r.code = spq_pkg::STAT_EMPTY;
			end else begin
				r.data = queued[0].data;
				r.prio = queued[0].prio;
				for (pos = 1; pos < queued_count; pos++)
					queued[pos-1] = queued[pos];
				queued_count--;
			end
		end
		r.empty = (queued_count == 0);
		r.full  = (queued_count == spq_pkg::DEPTH);
		outcomes_due.push_back(r);
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// compare each result beat with the oldest outstanding prediction
	always @(posedge clk) begin : check_results
		queue_result_t want;
		if (arst_n && done) begin
			if (outcomes_due.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, actual %0d %0h %0h",
					$time, status, front_data, front_priority);
				error_count++;
			end else begin
				want = outcomes_due.pop_front();
				check_field("status", want.code, status);
				check_field("front_data", want.data, front_data);
				check_field("front_priority", want.prio, front_priority);
				check_field("now_empty", want.empty, now_empty);
				check_field("now_full", want.full, now_full);
			end
		end
	end

	// drive one command beat and hold it until accepted; start stays high on return
	task automatic send_beat(input logic act,
			input logic signed [spq_pkg::DATA_W-1:0] data,
			input logic signed [spq_pkg::PRIO_W-1:0] prio);
		start         <= 1'b1;
		action        <= act;
		item_data     <= data;
		item_priority <= prio;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		model_queue_op(act, data, prio);
		beats_sent++;
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// hold off until every predicted result has been seen
	task automatic wait_for_drain();
		start <= 1'b0;
		@(posedge clk);
		while (outcomes_due.size() != 0)
			@(posedge clk);
	endtask

	// mostly a few clustered values so ties are common, sometimes the full range
	function automatic logic signed [spq_pkg::PRIO_W-1:0] pick_priority();
		logic [spq_pkg::PRIO_W-1:0] v;
		if ($urandom_range(0, 3) == 0) v = spq_pkg::PRIO_W'($urandom);
		else v = spq_pkg::PRIO_W'($urandom_range(0, 6)) - spq_pkg::PRIO_W'(3);
		return v;
	endfunction

	// refusals on an empty queue straight after reset
	task automatic test_empty_refusals();
		send_beat(ACT_DEQ, 32'h7fff_ffff, 16'sh7fff);
		send_beat(ACT_DEQ, 32'h8000_0000, 16'sh8000);
		idle_cycles(2);
	endtask

	// extreme data and priority values, served in priority order
	task automatic test_field_extremes();
		send_beat(ACT_ENQ, 32'h7fff_ffff, 16'sh7fff);
		send_beat(ACT_ENQ, 32'h8000_0000, 16'sh8000);
		send_beat(ACT_ENQ, 32'h0000_0000, 16'sh0000);
		send_beat(ACT_ENQ, 32'hffff_ffff, 16'shffff);
		send_beat(ACT_ENQ, 32'h5555_aaaa, 16'sh7fff);
		idle_cycles(3);
		repeat (5) send_beat(ACT_DEQ, 32'h0, 16'sh0);
		// last entry gone, next dequeue is refused
		send_beat(ACT_DEQ, 32'hdead_beef, 16'sh1234);
		idle_cycles(1);
	endtask

	// ties keep arrival order; a higher priority overtakes them
	task automatic test_equal_priority_order();
		send_beat(ACT_ENQ, 32'h0000_0001, 16'sd5);
		send_beat(ACT_ENQ, 32'h0000_0002, 16'sd5);
		send_beat(ACT_ENQ, 32'h0000_0003, 16'sd5);
		send_beat(ACT_ENQ, 32'h0000_0004, 16'sd6);
		send_beat(ACT_ENQ, 32'h0000_0005, 16'sd5);
		send_beat(ACT_ENQ, 32'h0000_0006, 16'sd4);
		repeat (6) send_beat(ACT_DEQ, 32'h0, 16'sh0);
		idle_cycles(2);
	endtask

	// fill to capacity, overflow, then drain past empty
	task automatic test_fill_and_overflow();
		wait_for_drain();
		repeat (spq_pkg::DEPTH) send_beat(ACT_ENQ, $urandom, pick_priority());
		send_beat(ACT_ENQ, $urandom, 16'sh7fff);
		send_beat(ACT_ENQ, $urandom, pick_priority());
		idle_cycles(4);
		repeat (spq_pkg::DEPTH) send_beat(ACT_DEQ, $urandom, pick_priority());
		send_beat(ACT_DEQ, $urandom, pick_priority());
	endtask

	// phases biased toward filling, draining or neither, sent in bursts
	task automatic test_random_traffic();
		int stop_at;
		int mode;
		int phase_len;
		int deq_pct;
		int burst_left;
		int n;
		logic act;
		stop_at = beats_sent + RANDOM_BEATS;
		burst_left = $urandom_range(1, 16);
		while (beats_sent < stop_at) begin
			mode = $urandom_range(0, 3);
			phase_len = $urandom_range(20, 80);
			case (mode)
				0: deq_pct = 20;
				1: deq_pct = 80;
				default: deq_pct = 50;
			endcase
			if ($urandom_range(0, 7) == 0)
				wait_for_drain();
			for (n = 0; n < phase_len; n++) begin
				act = ($urandom_range(0, 99) < deq_pct) ? ACT_DEQ : ACT_ENQ;
				send_beat(act, $urandom, pick_priority());
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					// the no-gap phase runs back to back
					if (mode != 3)
						idle_cycles($urandom_range(1, 6));
				end
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_refusals();
		test_field_extremes();
		test_equal_priority_order();
		test_fill_and_overflow();
		test_random_traffic();

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && outcomes_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
